// ===== rtl/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared types and constants of the RGB median filter core.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int MAX_WIDTH_D  = 256;
    localparam int MAX_HEIGHT_D = 256;
    localparam int MAX_WINDOW_D = 7;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SCAN,
        ST_WAIT,
        ST_DONE,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/rmf_frame_ram.sv =====
// ----------------------------------------------------------------------------
// rmf_frame_ram
// Frame store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rmf_frame_ram
    import rmf_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_D * MAX_HEIGHT_D,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [23:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [23:0]   rdata
);

    logic [23:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rgb_median_filter_core.sv =====
// ----------------------------------------------------------------------------
// rgb_median_filter_core
// Per-pixel RGB median over a frame store, found bit by bit per channel.
//
// Channel | Dir | Contents
// s_      | in  | tdata: cmd, col, row, red_in, green_in, blue_in
// m_      | out | tdata: red_out, green_out, blue_out, out_of_range
// cfg     | in  | APB: image_width, image_height, window_size
//
// A load in range writes the frame store. A request in range makes eight
// passes over its window, one per result bit, through one frame store read
// port. A waiting result holds off the input; the next item is taken in the
// cycle the result leaves. Reset is synchronous; the frame store is not cleared.
// ----------------------------------------------------------------------------
module rgb_median_filter_core
    import rmf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_D,
    parameter int MAX_HEIGHT = MAX_HEIGHT_D,
    parameter int MAX_WINDOW = MAX_WINDOW_D
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[0], col[8:1], row[16:9], red_in[24:17], green_in[32:25], blue_in[40:33]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16], out_of_range[24]
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = CW + RW;
    localparam int NW = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

    // configuration
    logic [8:0] width_reg, height_reg;
    logic [2:0] window_reg;
    logic       wr_en;
    logic [1:0] ridx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign ridx   = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            window_reg <= 3'd3;
        end else if (wr_en) begin
            case (ridx)
                REG_WIDTH:  width_reg  <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[8:0];
                REG_WINDOW: window_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_WIDTH:  prdata = {23'd0, width_reg};
            REG_HEIGHT: prdata = {23'd0, height_reg};
            REG_WINDOW: prdata = {29'd0, window_reg};
            default:    prdata = 32'd0;
        endcase
        if (paddr[1:0] != 2'b00) prdata = 32'd0;
    end

    // effective sizes (13 bits cover 4096)
    logic [12:0] w_eff, h_eff;
    logic [3:0]  ws_eff;
    logic [2:0]  half;
    always_comb begin
        w_eff  = ({4'd0, width_reg} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {4'd0, width_reg};
        h_eff  = ({4'd0, height_reg} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT)
                                                        : {4'd0, height_reg};
        ws_eff = ({1'b0, window_reg} > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : {1'b0, window_reg};
        half   = ws_eff[3:1];
    end

    // input fields
    logic        in_cmd;
    logic [7:0]  in_col, in_row;
    logic [23:0] in_px;
    logic        in_inside;
    assign in_cmd    = s_tdata[0];
    assign in_col    = s_tdata[8:1];
    assign in_row    = s_tdata[16:9];
    assign in_px     = {s_tdata[24:17], s_tdata[32:25], s_tdata[40:33]};
    assign in_inside = ({5'd0, in_col} < w_eff) && ({5'd0, in_row} < h_eff);

    state_t state_reg, state_next;

    logic [12:0] r0_reg, r0_next, r1_reg, r1_next, c0_reg, c0_next, c1_reg, c1_next;
    logic [12:0] r_reg, r_next, c_reg, c_next;
    logic [3:0]  pass_reg, pass_next;
    logic [2:0][7:0] pre_reg, pre_next;     // lower-middle prefix, per channel
    logic [2:0][7:0] pre2_reg, pre2_next;   // upper-middle prefix
    logic [2:0][NW-1:0] cnt_reg, cnt_next, cnt2_reg, cnt2_next;
    logic [2:0][NW-1:0] rank_reg, rank_next, rank2_reg, rank2_next;
    logic        vld_reg, vld_next;         // read data valid next cycle
    logic        m_valid_reg, m_valid_next;
    logic [24:0] m_data_reg, m_data_next;

    logic          s_fire, m_fire;
    logic [23:0]   rd;
    logic [AW-1:0] raddr;
    logic          ram_we;
    logic [7:0]    bitmask;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_valid_reg && m_tready;
    assign ram_we = s_fire && in_cmd == CMD_LOAD && in_inside;
    assign raddr  = {r_reg[RW-1:0], c_reg[CW-1:0]};

    rmf_frame_ram #(.DEPTH(1 << AW), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr ({RW'(in_row), CW'(in_col)}),
        .wdata (in_px),
        .raddr (raddr),
        .rdata (rd)
    );

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);

    // pass p (0..7) resolves bit 7-p
    assign bitmask = 8'h80 >> pass_reg[2:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire && in_cmd == CMD_REQUEST && in_inside) state_next = ST_COUNT;
            ST_COUNT: state_next = ST_SCAN;
            ST_SCAN: if (c_reg == c1_reg && r_reg == r1_reg) state_next = ST_WAIT;
            ST_WAIT: state_next = (pass_reg == 4'd7) ? ST_DONE : ST_SCAN;
            ST_DONE: state_next = ST_OUT;
            ST_OUT: if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        logic [7:0] ch;
        logic [7:0] cand;
        logic [2:0][7:0] p;
        logic [NW-1:0] n_win;
        ch = '0;
        cand = '0;
        n_win = '0;
        r0_next = r0_reg; r1_next = r1_reg; c0_next = c0_reg; c1_next = c1_reg;
        r_next = r_reg; c_next = c_reg;
        pass_next = pass_reg; pre_next = pre_reg; pre2_next = pre2_reg;
        cnt_next = cnt_reg; cnt2_next = cnt2_reg;
        rank_next = rank_reg; rank2_next = rank2_reg;
        vld_next = 1'b0;
        m_valid_next = m_fire ? 1'b0 : m_valid_reg;
        m_data_next = m_data_reg;
        p = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && in_cmd == CMD_REQUEST) begin
                    if (!in_inside) begin
                        m_valid_next = 1'b1;
                        m_data_next  = {1'b1, 24'd0};
                    end
                    r0_next = ({5'd0, in_row} >= {10'd0, half}) ?
                              {5'd0, in_row} - {10'd0, half} : 13'd0;
                    c0_next = ({5'd0, in_col} >= {10'd0, half}) ?
                              {5'd0, in_col} - {10'd0, half} : 13'd0;
                    r1_next = {5'd0, in_row} + {10'd0, half};
                    c1_next = {5'd0, in_col} + {10'd0, half};
                end
            end
            ST_COUNT: begin
                if (r1_reg > h_eff - 13'd1) r1_next = h_eff - 13'd1;
                if (c1_reg > w_eff - 13'd1) c1_next = w_eff - 13'd1;
                r_next = r0_reg;
                c_next = c0_reg;
                n_win = NW'(((r1_next - r0_reg + 13'd1) * (c1_next - c0_reg + 13'd1)));
                pass_next = 4'd0;
                pre_next = '0;
                pre2_next = '0;
                cnt_next = '0;
                cnt2_next = '0;
                for (int i = 0; i < 3; i++) begin
                    // zero-based ranks of lower and upper middle
                    rank_next[i]  = (n_win - NW'(1)) >> 1;
                    rank2_next[i] = n_win >> 1;
                end
            end
            ST_SCAN, ST_WAIT: begin
                if (state_reg == ST_SCAN) begin
                    vld_next = 1'b1;
                    if (c_reg == c1_reg) begin
                        c_next = c0_reg;
                        r_next = (r_reg == r1_reg) ? r0_reg : r_reg + 13'd1;
                    end else begin
                        c_next = c_reg + 13'd1;
                    end
                end
                if (vld_reg) begin
                    for (int i = 0; i < 3; i++) begin
                        ch = rd[23 - 8*i -: 8];
                        // count pixels matching prefix with current bit zero
                        if (((ch ^ pre_reg[i]) & ~((bitmask << 1) - 8'd1) & 8'hFF) == 8'd0
                            && (ch & bitmask) == 8'd0)
                            cnt_next[i] = cnt_reg[i] + NW'(1);
                        if (((ch ^ pre2_reg[i]) & ~((bitmask << 1) - 8'd1) & 8'hFF) == 8'd0
                            && (ch & bitmask) == 8'd0)
                            cnt2_next[i] = cnt2_reg[i] + NW'(1);
                    end
                end
                if (state_reg == ST_WAIT) begin
                    // resolve the current bit from this pass's counts
                    for (int i = 0; i < 3; i++) begin
                        if (rank_reg[i] >= cnt_next[i]) begin
                            pre_next[i]  = pre_reg[i] | bitmask;
                            rank_next[i] = rank_reg[i] - cnt_next[i];
                        end
                        if (rank2_reg[i] >= cnt2_next[i]) begin
                            pre2_next[i]  = pre2_reg[i] | bitmask;
                            rank2_next[i] = rank2_reg[i] - cnt2_next[i];
                        end
                    end
                    cnt_next  = '0;
                    cnt2_next = '0;
                    pass_next = pass_reg + 4'd1;
                end
            end
            ST_DONE: begin
                for (int i = 0; i < 3; i++) begin
                    cand = 8'(({1'b0, pre_reg[i]} + {1'b0, pre2_reg[i]}) >> 1);
                    p[i] = cand;
                end
                m_data_next = {1'b0, p[0], p[1], p[2]};
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, m_data_reg[23:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            vld_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            vld_reg     <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        r0_reg <= r0_next; r1_reg <= r1_next; c0_reg <= c0_next; c1_reg <= c1_next;
        r_reg <= r_next; c_reg <= c_next;
        pass_reg <= pass_next; pre_reg <= pre_next; pre2_reg <= pre2_next;
        cnt_reg <= cnt_next; cnt2_reg <= cnt2_next;
        rank_reg <= rank_next; rank2_reg <= rank2_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg[24], m_data_reg[7:0], m_data_reg[15:8],
                       m_data_reg[23:16]};

endmodule

// ===== rtl/rmf_checker.sv =====
// ----------------------------------------------------------------------------
// rmf_checker
// Port-level checks of the RGB median filter core.
// ----------------------------------------------------------------------------
module rmf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        pready
);

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

    a_oor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24] |-> m_tdata[23:0] == 24'd0)
        else $error("flagged result with nonzero channels");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while a result waits");

endmodule

bind rgb_median_filter_core rmf_checker u_rmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// ===== tb/rgb_median_filter_checker.sv =====
// ----------------------------------------------------------------------------
// rgb_median_filter_checker
// Watches both streams of the median filter core, keeps its own copy of the
// frame store and the size registers, predicts each filtered pixel and
// compares it field by field with the result stream.
// ----------------------------------------------------------------------------
module rgb_median_filter_checker
    import rmf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       flag;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_result_t;

    logic [23:0]   pixel_mem [0:MAX_WIDTH_D*MAX_HEIGHT_D-1];
    logic [8:0]    width_q;
    logic [8:0]    height_q;
    logic [2:0]    win_q;
    pixel_result_t median_q [$];

    function automatic logic [7:0] channel_median(logic [7:0] v [], int n);
        logic [7:0] t;
        int         j;
        if (n == 0) return 8'd0;
        for (int i = 1; i < n; i++) begin
            t = v[i];
            j = i;
            while (j > 0 && v[j-1] > t) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = t;
        end
        if (n % 2 == 0) return 8'((int'(v[n/2]) + int'(v[n/2-1])) / 2);
        return v[n/2];
    endfunction

    function automatic pixel_result_t filter_pixel(int col, int row);
        pixel_result_t res;
        logic [7:0]    rv [];
        logic [7:0]    gv [];
        logic [7:0]    bv [];
        int            w, h, half, r0, r1, c0, c1, n;
        logic [23:0]   px;
        w = (width_q > MAX_WIDTH_D) ? MAX_WIDTH_D : width_q;
        h = (height_q > MAX_HEIGHT_D) ? MAX_HEIGHT_D : height_q;
        res = '0;
        if (col >= w || row >= h) begin
            res.flag = 1'b1;
            return res;
        end
        half = ((win_q > MAX_WINDOW_D) ? MAX_WINDOW_D : win_q) / 2;
        r0 = (row >= half) ? row - half : 0;
        c0 = (col >= half) ? col - half : 0;
        r1 = (row + half > h - 1) ? h - 1 : row + half;
        c1 = (col + half > w - 1) ? w - 1 : col + half;
        n = (r1 - r0 + 1) * (c1 - c0 + 1);
        rv = new[n];
        gv = new[n];
        bv = new[n];
        n = 0;
        for (int r = r0; r <= r1; r++) begin
            for (int c = c0; c <= c1; c++) begin
                px = pixel_mem[r*MAX_WIDTH_D + c];
                rv[n] = px[23:16];
                gv[n] = px[15:8];
                bv[n] = px[7:0];
                n++;
            end
        end
        res.red = channel_median(rv, n);
        res.green = channel_median(gv, n);
        res.blue = channel_median(bv, n);
        return res;
    endfunction

    always @(posedge aclk) begin
        pixel_result_t got;
        pixel_result_t want;
        int            col, row, w, h;
        if (!aresetn) begin
            width_q <= 9'd256;
            height_q <= 9'd256;
            win_q <= 3'd3;
            median_q.delete();
            fail_count <= 0;
            pending <= 0;
            result_count <= 0;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_WIDTH:  width_q <= pwdata[8:0];
                    REG_HEIGHT: height_q <= pwdata[8:0];
                    REG_WINDOW: win_q <= pwdata[2:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[24:0];
                result_count <= result_count + 1;
                if (median_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = median_q.pop_front();
                    if (got !== want || m_tdata[31:25] !== 7'd0) begin
                        if (fail_count < 10)
                            $display("mismatch: expected r%h g%h b%h f%b, got r%h g%h b%h f%b",
                                     want.red, want.green, want.blue, want.flag,
                                     got.red, got.green, got.blue, got.flag);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                col = s_tdata[8:1];
                row = s_tdata[16:9];
                w = (width_q > MAX_WIDTH_D) ? MAX_WIDTH_D : width_q;
                h = (height_q > MAX_HEIGHT_D) ? MAX_HEIGHT_D : height_q;
                if (s_tdata[0] == CMD_LOAD) begin
                    if (col < w && row < h)
                        pixel_mem[row*MAX_WIDTH_D + col] = {s_tdata[24:17], s_tdata[32:25],
                                                            s_tdata[40:33]};
                end else begin
                    median_q.insert(median_q.size(), filter_pixel(col, row));
                end
            end
            pending <= median_q.size();
        end
    end
endmodule

// ===== tb/tb_rgb_median_filter_core.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_median_filter_core
// Stimulus for the RGB median filter core: fills small images, then asks
// for filtered pixels under several size and window settings, with bursty
// input and a stalling result side. The checker gives the verdict data.
// ----------------------------------------------------------------------------
module tb_rgb_median_filter_core;
    import rmf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // cmd, col, row, red_in, green_in, blue_in
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // red_out, green_out, blue_out, out_of_range
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, result_count;
    int          item_count;
    bit          hold_off;
    int          img_w, img_h;

    rgb_median_filter_core dut (.*);

    rgb_median_filter_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 9) == 0) stall = $urandom_range(1, 600);
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(logic cmd, int col, int row, logic [23:0] rgb);
        if ($urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, rgb[7:0], rgb[15:8], rgb[23:16], 8'(row), 8'(col), cmd};
        do @(posedge aclk); while (!s_tready);
        item_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    // fill a w by h image so that requests read written pixels
    task automatic fill_image(int w, int h, bit extremes);
        logic [23:0] rgb;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                rgb = extremes ? (($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000)
                               : 24'($urandom);
                send_item(CMD_LOAD, c, r, rgb);
            end
        end
    endtask

    task automatic set_image(int w, int h, int win);
        drain();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_WINDOW, win);
        img_w = (w > 256) ? 256 : w;
        img_h = (h > 256) ? 256 : h;
    endtask

    task automatic random_request();
        int c, r;
        if ($urandom_range(0, 7) == 0) begin
            send_item(CMD_REQUEST, $urandom_range(img_w, 255), $urandom_range(0, 255),
                      24'($urandom));
        end else begin
            c = $urandom_range(0, img_w - 1);
            r = $urandom_range(0, img_h - 1);
            send_item(CMD_REQUEST, c, r, 24'($urandom));
        end
    endtask

    initial begin
        int w, h;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_off = 1'b0;
        item_count = 0;
        img_w = 256;
        img_h = 256;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        set_image(4, 3, 3);
        fill_image(4, 3, 1);
        send_item(CMD_REQUEST, 0, 0, '0);
        send_item(CMD_REQUEST, 3, 2, '0);
        send_item(CMD_REQUEST, 1, 1, '0);
        send_item(CMD_REQUEST, 4, 0, '0);
        send_item(CMD_REQUEST, 255, 255, '0);
        send_item(CMD_LOAD, 200, 1, 24'hFFFFFF);
        set_image(4, 3, 0);
        send_item(CMD_REQUEST, 2, 1, '0);
        set_image(4, 3, 7);
        send_item(CMD_REQUEST, 2, 1, '0);
        set_image(4, 3, 2);
        send_item(CMD_REQUEST, 0, 2, '0);
        set_image(0, 3, 3);
        send_item(CMD_LOAD, 0, 0, 24'h123456);
        send_item(CMD_REQUEST, 0, 0, '0);
        set_image(511, 1, 5);
        send_item(CMD_LOAD, 255, 0, 24'hABCDEF);
        send_item(CMD_LOAD, 254, 0, 24'h102030);
        send_item(CMD_LOAD, 253, 0, 24'hF0E0D0);
        send_item(CMD_REQUEST, 255, 0, '0);

        for (int phase = 0; phase < 8; phase++) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            if (phase == 7) begin
                w = 256;
                h = 1;
            end
            set_image(w, h, $urandom_range(0, 7));
            fill_image((w > 40) ? 40 : w, h, 0);
            if (phase == 7) begin
                for (int c = 40; c < 256; c++) send_item(CMD_LOAD, c, 0, 24'($urandom));
            end
            if (phase == 3) hold_off = 1'b1;
            for (int k = 0; k < 60; k++) random_request();
            if (phase == 5) drain();
            for (int k = 0; k < 20; k++) begin
                send_item(CMD_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                          24'($urandom));
                random_request();
            end
        end

        drain();
        repeat (100) @(posedge aclk);
        $display("covered %0d items and %0d filtered pixels over eight image sizes and all",
                 item_count, result_count);
        $display("window sizes, including out-of-image loads and requests");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/rmf_pkg.sv
rtl/rmf_frame_ram.sv
rtl/rgb_median_filter_core.sv
rtl/rmf_checker.sv
tb/rgb_median_filter_checker.sv
tb/tb_rgb_median_filter_core.sv
